// ----- rtl/esld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package esld_pkg;

    localparam int COORD_W    = 7;
    localparam int COORD_SPAN = 1 << COORD_W;
    localparam int LEVEL_W    = 16;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] STEP_RESET = 16'd1311;

    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_DECAY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [LEVEL_W-1:0] intensity;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/event_surface_linear_decay_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Decaying activity surface for an event camera. Each pixel keeps a 16-bit
// level in one single-port-write, one-read synchronous memory of
// min(FRAME_WIDTH,128) x min(FRAME_HEIGHT,128) words (only the first 128
// columns and rows are addressable by the 7-bit coordinates). An event
// transfer (func = 0) sets its pixel to 65535 and returns nothing; a
// decay-and-read transfer (func = 1) lowers the pixel by decay_step, clamping
// at zero, writes it back and returns the new level with its coordinates.
// Coordinates outside the frame are dropped without effect. The block takes
// one transfer per cycle while in_stall is low: the memory read is issued at
// the accepting edge, and the read-modify-write completes, with any decay
// result loaded into the output register, at the edge where that stage
// advances. Back-to-back transfers to the same pixel are covered by a
// one-entry write forwarding register. in_stall rises only while the output
// register is full and stalled with a decay result waiting behind it, and for
// the clearing pass after reset, which zeroes one memory word per cycle
// across all min(FRAME_WIDTH,128) x min(FRAME_HEIGHT,128) words. decay_step may
// be written at any time, including during the clearing pass; change it
// only while no transfer is in flight.

module event_surface_linear_decay_top #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [esld_pkg::LEVEL_W-1:0] cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire esld_pkg::in_item_t           in_item,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output esld_pkg::out_item_t               out_item
);

    // Only the coordinate span can ever be reached, so size the store to it.
    localparam int COLS   = (FRAME_WIDTH < esld_pkg::COORD_SPAN) ?
                            FRAME_WIDTH : esld_pkg::COORD_SPAN;
    localparam int ROWS   = (FRAME_HEIGHT < esld_pkg::COORD_SPAN) ?
                            FRAME_HEIGHT : esld_pkg::COORD_SPAN;
    localparam int DEPTH  = COLS * ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration
    logic [esld_pkg::LEVEL_W-1:0] decay_step_reg;
    logic [esld_pkg::LEVEL_W-1:0] decay_step_next;

    // Input side
    logic              in_accept;
    logic              in_hit;
    logic [ADDR_W-1:0] in_addr;

    // Read-modify-write stage
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         s1_func_reg;
    logic [esld_pkg::COORD_W-1:0] s1_x_reg;
    logic [esld_pkg::COORD_W-1:0] s1_y_reg;
    logic [ADDR_W-1:0]            s1_addr_reg;
    logic                         s1_is_decay;
    logic                         s1_adv;

    // Last write, forwarded to a read that raced it
    logic                         fwd_valid_reg;
    logic                         fwd_valid_next;
    logic [ADDR_W-1:0]            fwd_addr_reg;
    logic [esld_pkg::LEVEL_W-1:0] fwd_data_reg;

    logic [esld_pkg::LEVEL_W-1:0] level_cur;
    logic [esld_pkg::LEVEL_W-1:0] level_new;
    logic [esld_pkg::LEVEL_W-1:0] wr_level;

    // Output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    esld_pkg::out_item_t  out_item_reg;
    logic                 out_load;

    // Memory ports and clearing pass
    logic                         clear_busy;
    logic [ADDR_W-1:0]            clear_addr;
    logic                         mem_rd_en;
    logic [esld_pkg::LEVEL_W-1:0] mem_rd_data;
    logic                         mem_wr_en;
    logic [ADDR_W-1:0]            mem_wr_addr;
    logic [esld_pkg::LEVEL_W-1:0] mem_wr_data;

    esld_clear_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clear_busy),
        .addr  (clear_addr)
    );

    esld_level_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (in_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Accept and address: drop out-of-frame transfers right here.
    assign in_accept = in_valid && !in_stall;
    assign in_hit    = (int'(in_item.pix_x) < COLS) && (int'(in_item.pix_y) < ROWS);
    assign in_addr   = ADDR_W'(int'(in_item.pix_y) * COLS + int'(in_item.pix_x));
    assign mem_rd_en = in_accept && in_hit;

    // An event needs no output slot; a decay result needs the output register
    // free or emptying this cycle.
    assign s1_is_decay = (s1_func_reg == esld_pkg::FUNC_DECAY);
    assign s1_adv      = s1_valid_reg && (!s1_is_decay || !out_valid_reg || !out_stall);
    assign in_stall    = clear_busy || (s1_valid_reg && !s1_adv);

    // The memory read missed a write made at the same edge: take the
    // forwarded word whenever the last write hit this address.
    assign level_cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ?
                       fwd_data_reg : mem_rd_data;
    // A zero level stays zero under the clamp, so no separate test is needed.
    assign level_new = (level_cur > decay_step_reg) ? (level_cur - decay_step_reg) : '0;
    assign wr_level  = s1_is_decay ? level_new : esld_pkg::FULL_LEVEL;

    // The clearing pass owns the write port; no transfer is in flight then.
    assign mem_wr_en   = clear_busy || s1_adv;
    assign mem_wr_addr = clear_busy ? clear_addr : s1_addr_reg;
    assign mem_wr_data = clear_busy ? '0 : wr_level;

    assign out_load = s1_adv && s1_is_decay;

    always_comb
    begin
        decay_step_next = decay_step_reg;
        if (cfg_wr_en)
        begin
            decay_step_next = cfg_wr_data;
        end

        // Advance into the stage on accept, drain it on advance, else hold.
        s1_valid_next = s1_valid_reg;
        if (mem_rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        fwd_valid_next = fwd_valid_reg || s1_adv;

        // Load a new result ahead of retiring the old one.
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_step_reg <= esld_pkg::STEP_RESET;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            decay_step_reg <= decay_step_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            s1_func_reg <= in_item.func;
            s1_x_reg    <= in_item.pix_x;
            s1_y_reg    <= in_item.pix_y;
            s1_addr_reg <= in_addr;
        end
        if (s1_adv)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= wr_level;
        end
        if (out_load)
        begin
            out_item_reg.out_x     <= s1_x_reg;
            out_item_reg.out_y     <= s1_y_reg;
            out_item_reg.intensity <= level_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // No transfer enters while the store is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> in_stall)
        else $error("input accepted during clearing pass");

    // The clearing pass never shares the write port with a pending update.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !s1_valid_reg)
        else $error("update pending during clearing pass");

    // A held update keeps its address, so its write-back lands on its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stalled update lost or moved");

endmodule

`default_nettype wire

// ----- rtl/esld_level_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module esld_level_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic [esld_pkg::LEVEL_W-1:0]     rd_data,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [esld_pkg::LEVEL_W-1:0] wr_data
);

    logic [esld_pkg::LEVEL_W-1:0] mem [DEPTH];
    logic [esld_pkg::LEVEL_W-1:0] rd_data_reg;

    // Read-first port pair: a read at the write address returns the old word.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/esld_clear_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module esld_clear_seq #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    output logic                   busy,
    output logic [ADDR_W-1:0]      addr
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    // Sweep every entry once after reset, then stay done.
    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg)
        begin
            if (addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign busy = busy_reg;
    assign addr = addr_reg;

endmodule

`default_nettype wire
